// ===== rtl/lcbp_pkg.sv =====
// Shared types and constants for the least-connection backend picker.
// Used by lcbp_table, the top level and the checker; no dependencies.
package lcbp_pkg;

    localparam int MAX_BACKENDS_DEF = 16;
    localparam int IN_IDX_W         = 4;
    localparam int ACT_W            = 16;
    localparam int LIFE_W           = 32;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 5;

    typedef enum logic [1:0] {
        CMD_OPEN       = 2'd0,
        CMD_RELEASE    = 2'd1,
        CMD_SET_STATUS = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKEND_COUNT = 1'b0,
        CFG_MASTER_MODE   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              act_we;
        logic              life_we;
        logic              flag_we;
        logic [ACT_W-1:0]  act;
        logic [LIFE_W-1:0] life;
        logic              run;
        logic              syn;
    } t_tbl_wr;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [LIFE_W-1:0] life;
        logic              run;
        logic              syn;
    } t_tbl_rd;

endpackage

// ===== rtl/lcbp_table.sv =====
// Backend table: active and lifetime count memories with per-entry valid bits,
// running and synced flags. One registered read port, one write port.
// Depends on lcbp_pkg.
module lcbp_table #(
    parameter int MAX_BACKENDS = lcbp_pkg::MAX_BACKENDS_DEF,
    parameter int IDX_W        = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output lcbp_pkg::t_tbl_rd    o_rd,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  lcbp_pkg::t_tbl_wr    i_wr
);

    logic [lcbp_pkg::ACT_W-1:0]  mem_act  [MAX_BACKENDS];
    logic [lcbp_pkg::LIFE_W-1:0] mem_life [MAX_BACKENDS];

    logic [MAX_BACKENDS-1:0] r_act_vld;
    logic [MAX_BACKENDS-1:0] r_life_vld;
    logic [MAX_BACKENDS-1:0] r_run;
    logic [MAX_BACKENDS-1:0] r_syn;

    logic [lcbp_pkg::ACT_W-1:0]  r_rd_act;
    logic [lcbp_pkg::LIFE_W-1:0] r_rd_life;
    logic                        r_rd_act_vld;
    logic                        r_rd_life_vld;
    logic                        r_rd_run;
    logic                        r_rd_syn;

    // memory arrays: no reset, covered by valid bits
    always_ff @(posedge i_clk) begin
        if (i_wr.act_we) begin
            mem_act[i_wr_addr] <= i_wr.act;
        end
        if (i_wr.life_we) begin
            mem_life[i_wr_addr] <= i_wr.life;
        end
        r_rd_act  <= mem_act[i_rd_addr];
        r_rd_life <= mem_life[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_vld     <= '0;
            r_life_vld    <= '0;
            r_run         <= '0;
            r_syn         <= '0;
            r_rd_act_vld  <= 1'b0;
            r_rd_life_vld <= 1'b0;
            r_rd_run      <= 1'b0;
            r_rd_syn      <= 1'b0;
        end else begin
            if (i_wr.act_we) begin
                r_act_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr.life_we) begin
                r_life_vld[i_wr_addr] <= 1'b1;
            end
            if (i_wr.flag_we) begin
                r_run[i_wr_addr] <= i_wr.run;
                r_syn[i_wr_addr] <= i_wr.syn;
            end
            r_rd_act_vld  <= r_act_vld[i_rd_addr];
            r_rd_life_vld <= r_life_vld[i_rd_addr];
            r_rd_run      <= r_run[i_rd_addr];
            r_rd_syn      <= r_syn[i_rd_addr];
        end
    end

    assign o_rd.act  = r_rd_act_vld  ? r_rd_act  : '0;
    assign o_rd.life = r_rd_life_vld ? r_rd_life : '0;
    assign o_rd.run  = r_rd_run;
    assign o_rd.syn  = r_rd_syn;

endmodule

// ===== rtl/least_connection_backend_picker_top.sv =====
// Least-connection backend picker, top level. Uses lcbp_pkg and lcbp_table.
// Open: scans the n entries in use (at least one) in S_SCAN, then S_DRAIN and S_WB, one
//   entry per cycle through a single compare unit over the table read port.
// Release, set status, no-op: states S_RD then S_EXEC. busy drops in the strobe cycle,
//   so the next transaction can start there. Results are strobed for one cycle; no stall.
// Synchronous active-low reset clears all flags, counts and configuration.
module least_connection_backend_picker_top #(
    parameter int MAX_BACKENDS = lcbp_pkg::MAX_BACKENDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_cmd,
    input  logic [lcbp_pkg::IN_IDX_W-1:0]     i_backend_index,
    input  logic                              i_running_flag,
    input  logic                              i_synced_flag,
    output logic                              o_result_valid,
    output logic [lcbp_pkg::IN_IDX_W-1:0]     o_chosen_index,
    output logic                              o_granted,
    output logic                              o_error_flag,
    output logic [lcbp_pkg::ACT_W-1:0]        o_active_after,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lcbp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lcbp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int IDX_W = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
    localparam int NW    = ($clog2(MAX_BACKENDS + 1) > lcbp_pkg::CFG_DATA_W) ?
                           $clog2(MAX_BACKENDS + 1) : lcbp_pkg::CFG_DATA_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WB    = 6'b001000,
        S_RD    = 6'b010000,
        S_EXEC  = 6'b100000
    } t_state;

    t_state r_state;

    logic [lcbp_pkg::CFG_DATA_W-1:0] r_backend_count;
    logic                            r_master_mode;

    lcbp_pkg::t_cmd                  r_cmd;
    logic [lcbp_pkg::IN_IDX_W-1:0]   r_idx;
    logic                            r_run_in;
    logic                            r_syn_in;

    logic [IDX_W-1:0]                r_cnt;
    logic                            r_pend;
    logic [IDX_W-1:0]                r_pend_idx;

    logic                            r_have_mst;
    logic                            r_have_cand;
    logic [IDX_W-1:0]                r_mst_idx;
    logic [lcbp_pkg::ACT_W-1:0]      r_mst_act;
    logic [lcbp_pkg::LIFE_W-1:0]     r_mst_life;
    logic [IDX_W-1:0]                r_cand_idx;
    logic [lcbp_pkg::ACT_W-1:0]      r_cand_act;
    logic [lcbp_pkg::LIFE_W-1:0]     r_cand_life;

    logic [NW-1:0]                   n_eff;
    logic [IDX_W-1:0]                rd_addr;
    logic [IDX_W-1:0]                wr_addr;
    lcbp_pkg::t_tbl_rd               rd;
    lcbp_pkg::t_tbl_wr               wr;

    logic                            scan_last;
    logic                            elig;
    logic                            better;
    logic                            use_cand;
    logic [IDX_W-1:0]                n_pick_idx;
    logic [lcbp_pkg::ACT_W-1:0]      n_pick_act;
    logic [lcbp_pkg::LIFE_W-1:0]     n_pick_life;
    logic [lcbp_pkg::ACT_W-1:0]      n_act_inc;
    logic [lcbp_pkg::LIFE_W-1:0]     n_life_inc;
    logic                            in_range;
    logic                            rel_ok;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != S_IDLE);

    assign n_eff = (NW'(r_backend_count) > NW'(MAX_BACKENDS)) ?
                   NW'(MAX_BACKENDS) : NW'(r_backend_count);

    assign scan_last = (NW'(r_cnt) + NW'(1)) >= n_eff;
    assign rd_addr   = (r_state == S_SCAN) ? r_cnt : IDX_W'(r_idx);

    assign elig   = r_pend && rd.run && rd.syn && (NW'(r_pend_idx) < n_eff);
    assign better = (rd.act < r_cand_act) ||
                    ((rd.act == r_cand_act) && (rd.life < r_cand_life));

    assign use_cand    = r_have_cand && !r_master_mode;
    assign n_pick_idx  = use_cand ? r_cand_idx  : r_mst_idx;
    assign n_pick_act  = use_cand ? r_cand_act  : r_mst_act;
    assign n_pick_life = use_cand ? r_cand_life : r_mst_life;
    assign n_act_inc   = (n_pick_act == '1) ? n_pick_act : n_pick_act + 1'b1;
    assign n_life_inc  = (n_pick_life == '1) ? n_pick_life : n_pick_life + 1'b1;

    assign in_range = NW'(r_idx) < n_eff;
    assign rel_ok   = in_range && (rd.act != '0);

    always_comb begin
        wr         = '0;
        wr_addr    = IDX_W'(r_idx);
        wr.run     = r_run_in;
        wr.syn     = r_syn_in;
        wr.act     = rd.act - 1'b1;
        wr.life    = n_life_inc;
        if (r_state == S_WB) begin
            wr_addr    = n_pick_idx;
            wr.act     = n_act_inc;
            wr.act_we  = r_have_mst;
            wr.life_we = r_have_mst;
        end else if (r_state == S_EXEC) begin
            wr.act_we  = (r_cmd == lcbp_pkg::CMD_RELEASE) && rel_ok;
            wr.flag_we = (r_cmd == lcbp_pkg::CMD_SET_STATUS) && in_range;
        end
    end

    lcbp_table #(
        .MAX_BACKENDS (MAX_BACKENDS),
        .IDX_W        (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    // candidate / master registers: payload, no reset
    always_ff @(posedge i_clk) begin
        if (elig) begin
            if (!r_have_mst) begin
                r_mst_idx  <= r_pend_idx;
                r_mst_act  <= rd.act;
                r_mst_life <= rd.life;
            end else if (!r_have_cand || better) begin
                r_cand_idx  <= r_pend_idx;
                r_cand_act  <= rd.act;
                r_cand_life <= rd.life;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd    <= lcbp_pkg::t_cmd'(i_cmd);
            r_idx    <= i_backend_index;
            r_run_in <= i_running_flag;
            r_syn_in <= i_synced_flag;
        end
        r_pend_idx <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_backend_count <= '0;
            r_master_mode   <= 1'b0;
            r_cnt           <= '0;
            r_pend          <= 1'b0;
            r_have_mst      <= 1'b0;
            r_have_cand     <= 1'b0;
            o_result_valid  <= 1'b0;
            o_chosen_index  <= '0;
            o_granted       <= 1'b0;
            o_error_flag    <= 1'b0;
            o_active_after  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (lcbp_pkg::t_cfg_reg'(i_cfg_index))
                    lcbp_pkg::CFG_BACKEND_COUNT: r_backend_count <= i_cfg_data;
                    lcbp_pkg::CFG_MASTER_MODE:   r_master_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            r_pend         <= (r_state == S_SCAN);
            o_result_valid <= 1'b0;

            if (elig) begin
                if (!r_have_mst) begin
                    r_have_mst <= 1'b1;
                end else begin
                    r_have_cand <= 1'b1;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cnt       <= '0;
                        r_have_mst  <= 1'b0;
                        r_have_cand <= 1'b0;
                        if (lcbp_pkg::t_cmd'(i_cmd) == lcbp_pkg::CMD_OPEN) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (scan_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    o_result_valid <= 1'b1;
                    o_error_flag   <= 1'b0;
                    o_granted      <= r_have_mst;
                    o_chosen_index <= r_have_mst ? lcbp_pkg::IN_IDX_W'(n_pick_idx) : '0;
                    o_active_after <= r_have_mst ? n_act_inc : '0;
                    r_state        <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    o_result_valid <= 1'b1;
                    o_granted      <= 1'b0;
                    o_chosen_index <= r_idx;
                    unique case (r_cmd)
                        lcbp_pkg::CMD_RELEASE: begin
                            o_error_flag   <= !rel_ok;
                            o_active_after <= rel_ok ? rd.act - 1'b1 : '0;
                        end
                        lcbp_pkg::CMD_SET_STATUS: begin
                            o_error_flag   <= !in_range;
                            o_active_after <= in_range ? rd.act : '0;
                        end
                        default: begin
                            o_error_flag   <= 1'b0;
                            o_active_after <= in_range ? rd.act : '0;
                        end
                    endcase
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/lcbp_checker.sv =====
// Port-level checker for the least-connection backend picker, bound to the top.
// Depends on lcbp_pkg for field widths.
module lcbp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic                              o_granted,
    input logic                              o_error_flag,
    input logic [lcbp_pkg::ACT_W-1:0]        o_active_after
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a transaction in flight");

    a_grant_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_granted |-> !o_error_flag && (o_active_after != '0))
        else $error("grant with error or zero active count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_error_flag |-> (o_active_after == '0) && !o_granted)
        else $error("error result carries a count or grant");

endmodule

bind least_connection_backend_picker_top lcbp_checker u_lcbp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_granted      (o_granted),
    .o_error_flag   (o_error_flag),
    .o_active_after (o_active_after)
);
